// File: rtl/core/sme_pkg.sv
// Shared types and constants for the stack machine executor.
// No dependencies; imported by every module of the block.
package sme_pkg;
   localparam int DataDepth   = 64;
   localparam int RegTotal    = 8;
   localparam int RetDepth    = 16;
   localparam int ProgramMax  = 1024;
   localparam int WordBits    = 32;
   localparam int DsAw        = $clog2(DataDepth);
   localparam int RsAw        = $clog2(RetDepth);
   localparam int RfAw        = (RegTotal > 1) ? $clog2(RegTotal) : 1;
   localparam logic [10:0] LimitReset = 11'd1000;

   typedef enum logic [4:0] {
      OP_PUSH = 5'd0, OP_POP = 5'd1, OP_DUP = 5'd2, OP_SWAP = 5'd3, OP_SETREG = 5'd4,
      OP_ADD = 5'd5, OP_SUB = 5'd6, OP_MUL = 5'd7, OP_DIV = 5'd8, OP_PRINT = 5'd9,
      OP_PRINTC = 5'd10, OP_INPUT = 5'd11, OP_JMP = 5'd12, OP_JIZ = 5'd13,
      OP_JNZ = 5'd14, OP_JIP = 5'd15, OP_JIN = 5'd16, OP_CALL = 5'd17,
      OP_RET = 5'd18, OP_END = 5'd19, OP_RESTART = 5'd20
   } op_type;

   typedef enum logic [3:0] {
      ST_OK = 4'd0, ST_UNDER = 4'd1, ST_BADREG = 4'd2, ST_DIVZERO = 4'd3,
      ST_NOINPUT = 4'd4, ST_BOUND = 4'd5, ST_RSUNDER = 4'd6, ST_BADOP = 4'd7,
      ST_OVER = 4'd8, ST_RSOVER = 4'd9, ST_LIMIT = 4'd10
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_EXEC, S_DIV, S_DONE
   } state_type;

   localparam logic [4:0] CsrLength = 5'd0;
   localparam logic [4:0] CsrLimit  = 5'd1;

   // controller -> datapath
   typedef struct packed {
      logic capture;   // latch the instruction
      logic read;      // stack reads issued
      logic exec;      // evaluate and commit
      logic div_start;
      logic div_step;
      logic div_commit;
      logic out_load;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic need_div;
      logic div_done;
   } stat_type;
endpackage

// File: rtl/core/sme_ctrl.sv
// Sequencer for the stack machine executor.
// Depends on sme_pkg; drives the datapath command struct.
module sme_ctrl
   import sme_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_fire,
   input  logic     out_free,
   input  stat_type stat,
   output cmd_type  cmd,
   output logic     busy
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req_fire) state_in = S_READ;
         S_READ: state_in = S_EXEC;
         S_EXEC: state_in = stat.need_div ? S_DIV : S_DONE;
         S_DIV:  if (stat.div_done) state_in = S_DONE;
         S_DONE: if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd = '0;
      cmd.capture = (state_ff == S_IDLE) && req_fire;
      unique case (state_ff)
         S_READ: cmd.read = 1'b1;
         S_EXEC: begin
            cmd.exec = 1'b1;
            cmd.div_start = stat.need_div;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cmd.div_commit = stat.div_done;
         end
         S_DONE: cmd.out_load = out_free;
         default: ;
      endcase
   end
   assign busy = (state_ff != S_IDLE);
endmodule

// File: rtl/core/sme_dpath.sv
// Datapath: stacks, register file, program counter, divider, result register.
// Depends on sme_pkg; sequenced by sme_ctrl.
module sme_dpath
   import sme_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output stat_type    stat,
   input  logic [4:0]  in_action,
   input  logic [31:0] in_operand,
   input  logic [4:0]  in_reg,
   input  logic [31:0] in_value,
   input  logic        in_present,
   input  logic        cfg_we,
   input  logic [4:0]  cfg_idx,
   input  logic [10:0] cfg_data,
   input  logic        out_pop,
   output logic        out_valid,
   output logic [49:0] out_data
);
   logic [WordBits-1:0] ds_mem [DataDepth];
   logic [10:0]         rs_mem [RetDepth];
   logic [WordBits-1:0] rf_ff [RegTotal];
   logic [DsAw:0]       dsc_ff;
   logic [RsAw:0]       rsc_ff;
   logic [10:0]         pc_ff, exc_ff, len_ff, lim_ff;
   logic                stop_ff;

   logic [4:0]          act_ff;
   logic [31:0]         opd_ff, inv_ff;
   logic [4:0]          ri_ff;
   logic                prs_ff;
   logic [WordBits-1:0] top_ff, sec_ff;
   logic [10:0]         rsr_ff;

   // capture instruction
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff <= in_action; opd_ff <= in_operand; ri_ff <= in_reg;
         inv_ff <= in_value; prs_ff <= in_present;
      end
   end

   // registered stack reads
   logic [DsAw-1:0] top_a, sec_a;
   assign top_a = DsAw'(dsc_ff - 1'b1);
   assign sec_a = DsAw'(dsc_ff - 2'd2);
   always_ff @(posedge clock) begin
      if (cmd.read) begin
         top_ff <= ds_mem[top_a];
         sec_ff <= ds_mem[sec_a];
         rsr_ff <= rs_mem[RsAw'(rsc_ff - 1'b1)];
      end
   end

   // decode helpers
   logic                neg, badreg, has_top;
   logic [RfAw-1:0]     ri;
   logic [WordBits-1:0] op_w, rval, bval;
   logic [10:0]         len, succ;
   assign neg    = ri_ff[4];
   assign badreg = !neg && (ri_ff[3:0] >= 4'(RegTotal));
   assign ri     = RfAw'(ri_ff[3:0]);
   assign op_w   = WordBits'(signed'(opd_ff));
   assign rval   = rf_ff[ri];
   assign bval   = neg ? op_w : rval;
   assign has_top = (dsc_ff != '0);
   assign len    = (len_ff > 11'(ProgramMax)) ? 11'(ProgramMax) : len_ff;
   assign succ   = (pc_ff + 11'd1 > len) ? len : pc_ff + 11'd1;

   // jump target: pc + op - 1 in [0,len]
   logic signed [33:0] jt;
   logic               jok;
   logic [10:0]        jpc;
   assign jt  = $signed({23'd0, pc_ff}) + $signed({{2{opd_ff[31]}}, opd_ff}) - 34'sd1;
   assign jok = (jt >= 0) && (jt <= $signed({23'd0, len}));
   assign jpc = (jt[10:0] + 11'd1 > len) ? len : jt[10:0] + 11'd1;

   logic [2*WordBits-1:0] prod_full;
   assign prod_full = top_ff * bval;

   // execute
   logic [3:0]  st;
   logic [10:0] npc;
   logic        pv, pch, halt_idle, ds_we, rf_we, rs_we, need_div, is_restart;
   logic [DsAw-1:0] ds_wa;
   logic [WordBits-1:0] ds_wd, rf_wd, pvv;
   logic        ds_we2;
   logic [WordBits-1:0] ds_wd2;
   logic [DsAw:0] dsc_nx;
   logic [RsAw:0] rsc_nx;
   logic        cond;
   always_comb begin
      st = ST_OK; npc = succ; pv = 0; pch = 0; pvv = '0;
      ds_we = 0; ds_wa = top_a; ds_wd = '0; ds_we2 = 0; ds_wd2 = top_ff;
      rf_we = 0; rf_wd = '0; rs_we = 0; need_div = 0;
      dsc_nx = dsc_ff; rsc_nx = rsc_ff; cond = 0;
      is_restart = (act_ff == OP_RESTART);
      halt_idle = stop_ff || (pc_ff >= len);
      case (act_ff)
         OP_PUSH: if (badreg) st = ST_BADREG;
            else if (dsc_ff >= (DsAw+1)'(DataDepth)) st = ST_OVER;
            else begin ds_we = 1; ds_wa = DsAw'(dsc_ff); ds_wd = bval; dsc_nx = dsc_ff + 1'b1; end
         OP_POP: if (!has_top) st = ST_UNDER; else if (badreg) st = ST_BADREG;
            else begin dsc_nx = dsc_ff - 1'b1; rf_we = !neg; rf_wd = top_ff; end
         OP_DUP: if (!has_top) st = ST_UNDER;
            else if (dsc_ff >= (DsAw+1)'(DataDepth)) st = ST_OVER;
            else begin ds_we = 1; ds_wa = DsAw'(dsc_ff); ds_wd = top_ff; dsc_nx = dsc_ff + 1'b1; end
         OP_SWAP: if (neg) begin
               if (dsc_ff < (DsAw+1)'(2)) st = ST_UNDER;
               else begin ds_we = 1; ds_wd = sec_ff; ds_we2 = 1; end
            end else if (!has_top) st = ST_UNDER; else if (badreg) st = ST_BADREG;
            else begin ds_we = 1; ds_wd = rval; rf_we = 1; rf_wd = top_ff; end
         OP_SETREG: if (neg || badreg) st = ST_BADREG;
            else begin rf_we = 1; rf_wd = op_w; end
         OP_ADD, OP_SUB, OP_MUL: if (!has_top) st = ST_UNDER;
            else if (badreg) st = ST_BADREG;
            else begin
               ds_we = 1;
               ds_wd = (act_ff == OP_ADD) ? top_ff + bval :
                       (act_ff == OP_SUB) ? top_ff - bval : prod_full[WordBits-1:0];
            end
         OP_DIV: if (badreg) st = ST_BADREG; else if (bval == '0) st = ST_DIVZERO;
            else if (!has_top) st = ST_UNDER; else need_div = 1;
         OP_PRINT, OP_PRINTC: begin
            if (neg) begin
               if (!has_top) st = ST_UNDER; else dsc_nx = dsc_ff - 1'b1;
            end else if (badreg) st = ST_BADREG;
            pv = 1; pch = (act_ff == OP_PRINTC);
            pvv = neg ? top_ff : rval;
            if (pch) pvv = {{(WordBits-8){1'b0}}, pvv[7:0]};
         end
         OP_INPUT: if (!prs_ff) st = ST_NOINPUT;
            else if (neg) begin
               if (dsc_ff >= (DsAw+1)'(DataDepth)) st = ST_OVER;
               else begin ds_we = 1; ds_wa = DsAw'(dsc_ff);
                  ds_wd = WordBits'(signed'(inv_ff)); dsc_nx = dsc_ff + 1'b1; end
            end else if (badreg) st = ST_BADREG;
            else begin rf_we = 1; rf_wd = WordBits'(signed'(inv_ff)); end
         OP_JMP: if (!jok) st = ST_BOUND; else npc = jpc;
         OP_JIZ, OP_JNZ, OP_JIP, OP_JIN: begin
            if (neg && !has_top) st = ST_UNDER;
            else if (!neg && badreg) st = ST_BADREG;
            else begin
               case (act_ff)
                  OP_JIZ: cond = (bval == '0);
                  OP_JNZ: cond = (bval != '0);
                  OP_JIP: cond = (bval != '0) && !bval[WordBits-1];
                  default: cond = bval[WordBits-1];
               endcase
               if (cond) begin if (!jok) st = ST_BOUND; else npc = jpc; end
            end
            if (neg) begin // stack form tests top
               cond = 0;
               if (has_top) begin
                  case (act_ff)
                     OP_JIZ: cond = (top_ff == '0);
                     OP_JNZ: cond = (top_ff != '0);
                     OP_JIP: cond = (top_ff != '0) && !top_ff[WordBits-1];
                     default: cond = top_ff[WordBits-1];
                  endcase
                  st = ST_OK; npc = succ;
                  if (cond) begin if (!jok) st = ST_BOUND; else npc = jpc; end
               end
            end
         end
         OP_CALL: if (rsc_ff >= (RsAw+1)'(RetDepth)) st = ST_RSOVER;
            else if (!jok) st = ST_BOUND;
            else begin npc = jpc; rs_we = 1; rsc_nx = rsc_ff + 1'b1; end
         OP_RET: if (rsc_ff == '0) st = ST_RSUNDER;
            else begin rsc_nx = rsc_ff - 1'b1;
               npc = (rsr_ff + 11'd1 > len) ? len : rsr_ff + 11'd1; end
         OP_END: npc = len;
         default: st = ST_BADOP;
      endcase
      if (st != ST_OK) pv = 0;
   end

   assign stat.need_div = !is_restart && !halt_idle && (st == ST_OK) && need_div;

   // restoring divider on magnitudes, one quotient bit per cycle
   logic [WordBits-1:0] dq_ff, dr_ff, dd_ff;
   logic                dneg_ff;
   logic [$clog2(WordBits+1)-1:0] dcnt_ff;
   logic [WordBits-1:0] amag, bmag;
   logic [WordBits:0]   trial;
   assign amag = top_ff[WordBits-1] ? -top_ff : top_ff;
   assign bmag = bval[WordBits-1] ? -bval : bval;
   assign trial = {dr_ff, dq_ff[WordBits-1]} - {1'b0, dd_ff};
   assign stat.div_done = (dcnt_ff == '0);
   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         dq_ff <= amag; dr_ff <= '0; dd_ff <= bmag;
         dneg_ff <= top_ff[WordBits-1] ^ bval[WordBits-1];
         dcnt_ff <= ($clog2(WordBits+1))'(WordBits);
      end else if (cmd.div_step && dcnt_ff != '0) begin
         dcnt_ff <= dcnt_ff - 1'b1;
         if (!trial[WordBits]) begin
            dr_ff <= trial[WordBits-1:0]; dq_ff <= {dq_ff[WordBits-2:0], 1'b1};
         end else begin
            dr_ff <= {dr_ff[WordBits-2:0], dq_ff[WordBits-1]};
            dq_ff <= {dq_ff[WordBits-2:0], 1'b0};
         end
      end
   end

   // commit and result
   logic        ok_commit, lim_hit;
   logic [3:0]  r_st;
   logic [10:0] r_na;
   logic        r_pv, r_pch, r_h;
   logic [31:0] r_pvv;
   assign ok_commit = cmd.exec && !is_restart && !halt_idle && (st == ST_OK);
   assign lim_hit = exc_ff > lim_ff;

   always_ff @(posedge clock) begin
      if (ok_commit && ds_we && !need_div) ds_mem[ds_wa] <= ds_wd;
      else if (cmd.div_commit) ds_mem[top_a] <= dneg_ff ? -dq_ff : dq_ff;
      if (ok_commit && ds_we2) ds_mem[sec_a] <= ds_wd2;
      if (ok_commit && rs_we) rs_mem[RsAw'(rsc_ff)] <= pc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dsc_ff <= '0; rsc_ff <= '0; pc_ff <= '0; exc_ff <= '0; stop_ff <= 1'b0;
         len_ff <= '0; lim_ff <= LimitReset;
         for (int i = 0; i < RegTotal; i++) rf_ff[i] <= '0;
      end else begin
         if (cfg_we && cfg_idx == CsrLength) len_ff <= cfg_data;
         if (cfg_we && cfg_idx == CsrLimit) lim_ff <= cfg_data;
         if (cmd.exec && is_restart) begin
            pc_ff <= '0; rsc_ff <= '0; exc_ff <= '0; stop_ff <= 1'b0;
            for (int i = 0; i < RegTotal; i++) rf_ff[i] <= '0;
         end else if (cmd.exec && !halt_idle) begin
            if (st != ST_OK) stop_ff <= 1'b1;
            else begin
               dsc_ff <= dsc_nx; rsc_ff <= rsc_nx; pc_ff <= npc;
               if (rf_we) rf_ff[ri] <= rf_wd;
               if (lim_hit) stop_ff <= 1'b1;
               if (exc_ff != 11'd2047) exc_ff <= exc_ff + 1'b1;
            end
         end
      end
   end

   // pending result, built at exec
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         if (is_restart) begin
            r_na <= '0; r_st <= ST_OK; r_pv <= 0; r_pch <= 0; r_pvv <= '0;
            r_h <= (len == '0);
         end else if (halt_idle) begin
            r_na <= pc_ff; r_st <= ST_OK; r_pv <= 0; r_pch <= 0; r_pvv <= '0; r_h <= 1;
         end else if (st != ST_OK) begin
            r_na <= pc_ff; r_st <= st; r_pv <= 0; r_pch <= 0; r_pvv <= '0; r_h <= 1;
         end else begin
            r_na <= npc; r_st <= lim_hit ? ST_LIMIT : ST_OK; r_pv <= pv; r_pch <= pch;
            r_pvv <= 32'(pvv); r_h <= lim_hit || (npc >= len);
         end
      end
   end

   // output register
   logic        ov_ff;
   logic [49:0] od_ff;
   always_ff @(posedge clock) begin
      if (reset) ov_ff <= 1'b0;
      else if (cmd.out_load) ov_ff <= 1'b1;
      else if (out_pop) ov_ff <= 1'b0;
      if (cmd.out_load) od_ff <= {r_h, r_pvv, r_pch, r_pv, r_st, r_na};
   end
   assign out_valid = ov_ff;
   assign out_data  = od_ff;

   // an error result always reports halted
   a_err_halts: assert property (@(posedge clock) disable iff (reset)
      out_valid && od_ff[14:11] != ST_OK |-> od_ff[49]) else $error("error not halted");
   // stack count never passes depth
   a_ds_bound: assert property (@(posedge clock) disable iff (reset)
      dsc_ff <= (DsAw+1)'(DataDepth)) else $error("data stack count overflow");
   a_rs_bound: assert property (@(posedge clock) disable iff (reset)
      rsc_ff <= (RsAw+1)'(RetDepth)) else $error("return stack count overflow");
   // no print without ok or limit status
   a_print: assert property (@(posedge clock) disable iff (reset)
      out_valid && od_ff[15] |-> (od_ff[14:11] == ST_OK || od_ff[14:11] == ST_LIMIT))
      else $error("print on error");
endmodule

// File: rtl/core/stack_machine_execute.sv
// Top level of the stack machine executor: handshakes, sequencer and datapath.
// Depends on sme_pkg, sme_ctrl and sme_dpath.
//
// Executes one stack-machine instruction per transfer on req_ and returns one
// result on rsp_. An instruction passes through capture, stack read, execute and
// result load; a divide adds the bit-serial divider (32 quotient steps and a
// write-back). A new instruction is taken once the previous result
// sits in the rsp_ register; the sequencer handles one instruction at a time.
// Configuration writes on csr_ are taken at any time and belong in idle periods.
module stack_machine_execute
   import sme_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [4:0] action, [36:5] operand, [41:37] reg_index, [73:42] input_value,
   // [74] input_present, [79:75] zero
   input  logic [79:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [10:0] next_address, [14:11] status, [15] print_valid, [16] print_is_char,
   // [48:17] print_value, [49] halted, [55:50] zero
   output logic [55:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_index,
   input  logic [10:0] csr_data
);
   cmd_type  cmd;
   stat_type stat;
   logic     busy, ov, fire, pop;
   logic [49:0] od;

   assign req_tready = !busy;
   assign fire = req_tvalid && req_tready;
   assign pop  = rsp_tvalid && rsp_tready;
   assign csr_ready = 1'b1;

   sme_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_fire(fire), .out_free(!ov || rsp_tready),
      .stat(stat), .cmd(cmd), .busy(busy));

   sme_dpath u_dpath (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .in_action(req_tdata[4:0]), .in_operand(req_tdata[36:5]),
      .in_reg(req_tdata[41:37]), .in_value(req_tdata[73:42]),
      .in_present(req_tdata[74]),
      .cfg_we(csr_valid), .cfg_idx(csr_index), .cfg_data(csr_data),
      .out_pop(pop), .out_valid(ov), .out_data(od));

   assign rsp_tvalid = ov;
   assign rsp_tdata  = {6'd0, od};
endmodule
